// File: rtl/fac_pkg.sv
package fac_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int BOX_W           = 32;
    localparam int ENTRY_W         = 32;
    localparam int OP_W            = 2;
    localparam int INDEX_W         = 4;
    localparam int TDATA_IN_W      = 232;
    localparam int TUSER_IN_W      = 3;
    localparam int TDATA_OUT_W     = 8;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

    // 4 rows x 4 columns x 4 products for the clip matrix.
    localparam int BUILD_STEPS = 64;
    localparam int BUILD_DRAIN = 3;
    localparam int PLANES      = 6;
    localparam int TEST_DRAIN  = 1;
    localparam int CNT_W       = 7;

    typedef struct packed {
        logic       load_en;
        logic       build_issue;
        logic [5:0] step;
        logic       test_start;
        logic       test_issue;
        logic [2:0] plane;
    } fac_cmd_t;

    typedef struct packed {
        logic culled;
    } fac_status_t;

endpackage

// File: rtl/fac_ctrl.sv
module fac_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [fac_pkg::OP_W-1:0]  in_op,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_visible,
    output fac_pkg::fac_cmd_t         cmd,
    input  fac_pkg::fac_status_t      status
);
    import fac_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_TEST
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             visible_reg;
    logic             accept;
    logic             test_done;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign out_visible = visible_reg;
    assign test_done   = (state_reg == S_TEST)
                      && (cnt_reg == CNT_W'(PLANES + TEST_DRAIN))
                      && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd             = '0;
        cmd.load_en     = accept && (in_op == OP_LOAD);
        cmd.test_start  = accept && (in_op == OP_TEST);
        cmd.build_issue = (state_reg == S_BUILD) && (cnt_reg < CNT_W'(BUILD_STEPS));
        cmd.step        = cnt_reg[5:0];
        cmd.test_issue  = (state_reg == S_TEST) && (cnt_reg < CNT_W'(PLANES));
        cmd.plane       = cnt_reg[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !test_done)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && (in_op == OP_BUILD))
                    begin
                        state_reg <= S_BUILD;
                    end
                    else if (accept && (in_op == OP_TEST))
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_BUILD:
                begin
                    if (cnt_reg == CNT_W'(BUILD_STEPS + BUILD_DRAIN))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_TEST:
                begin
                    if (test_done)
                    begin
                        out_valid_reg <= 1'b1;
                        visible_reg   <= !status.culled;
                        state_reg     <= S_IDLE;
                    end
                    else if (cnt_reg != CNT_W'(PLANES + TEST_DRAIN))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_mixed_issue: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.build_issue && cmd.test_issue))
        else $error("build and test issued together");

    a_result_from_test: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_TEST))
        else $error("result word raised outside a box test");

    a_test_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> (cnt_reg <= CNT_W'(PLANES + TEST_DRAIN)))
        else $error("test counter overran");

    a_busy_after_build: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_BUILD)) |=> !in_ready)
        else $error("ready while building planes");
`endif

endmodule

// File: rtl/fac_datapath.sv
module fac_datapath #(
    parameter int VALUE_WIDTH = fac_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fac_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fac_pkg::fac_cmd_t                   cmd,
    output fac_pkg::fac_status_t                status,
    input  logic                                which_matrix,
    input  logic [fac_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [fac_pkg::ENTRY_W-1:0]  entry_value,
    input  logic signed [fac_pkg::BOX_W-1:0]    box_x_min,
    input  logic signed [fac_pkg::BOX_W-1:0]    box_y_min,
    input  logic signed [fac_pkg::BOX_W-1:0]    box_z_min,
    input  logic signed [fac_pkg::BOX_W-1:0]    box_x_max,
    input  logic signed [fac_pkg::BOX_W-1:0]    box_y_max,
    input  logic signed [fac_pkg::BOX_W-1:0]    box_z_max
);
    import fac_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int PW     = VW + 1;
    localparam int MUL_W  = 2 * VW;
    localparam int ACC_W  = MUL_W + 2;
    localparam int PROD_W = PW + BOX_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [ENTRY_W-1:0] LMAX = ENTRY_W'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [ENTRY_W-1:0] LMIN = -LMAX - 1;
    localparam logic signed [ACC_W-1:0]   CMAX = ACC_W'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0]   CMIN = -CMAX - 1;

    logic signed [VW-1:0]    mv_reg [16];
    logic signed [VW-1:0]    pr_reg [16];
    logic signed [PW-1:0]    plane_reg [24];
    logic signed [VW-1:0]    load_val;

    // Clip matrix pipeline: multiply, accumulate, floor and saturate, and write planes.
    logic signed [MUL_W-1:0] prod_reg;
    logic                    a_valid_reg;
    logic [5:0]              a_tag_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    b_last_reg;
    logic [3:0]              b_tag_reg;
    logic signed [VW-1:0]    w_reg;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [VW-1:0]    clip;
    logic [1:0]              row_a;
    logic [1:0]              col_a;
    logic [1:0]              k_a;
    logic [1:0]              axis_c;

    // Box test pipeline.
    logic signed [BOX_W-1:0]  bx_lo_reg, by_lo_reg, bz_lo_reg;
    logic signed [BOX_W-1:0]  bx_hi_reg, by_hi_reg, bz_hi_reg;
    logic signed [PW-1:0]     pa, pb, pc, pd;
    logic signed [BOX_W-1:0]  xs, ys, zs;
    logic signed [PROD_W-1:0] ma_reg, mb_reg, mc_reg;
    logic signed [SUM_W-1:0]  md_reg;
    logic                     nz_reg;
    logic                     t_valid_reg;
    logic signed [SUM_W-1:0]  vsum;
    logic                     cull_reg;

    always_comb
    begin
        if (entry_value > LMAX)
        begin
            load_val = LMAX[VW-1:0];
        end
        else if (entry_value < LMIN)
        begin
            load_val = LMIN[VW-1:0];
        end
        else
        begin
            load_val = entry_value[VW-1:0];
        end
    end

    // Rows are walked with the w column first so it is held for the other three.
    assign row_a = cmd.step[5:4];
    assign col_a = cmd.step[3:2] + 2'd3;
    assign k_a   = cmd.step[1:0];

    always_comb
    begin
        acc_sh = acc_reg >>> FRAC_BITS;
        if (acc_sh > CMAX)
        begin
            clip = CMAX[VW-1:0];
        end
        else if (acc_sh < CMIN)
        begin
            clip = CMIN[VW-1:0];
        end
        else
        begin
            clip = acc_sh[VW-1:0];
        end
        axis_c = b_tag_reg[1:0] - 2'd1;
    end

    // Positive vertex: the corner that maximizes the plane value. The bounds
    // may come swapped, so the larger of the two is taken for a positive
    // coefficient and the smaller for a negative one.
    always_comb
    begin
        pa   = plane_reg[{cmd.plane, 2'd0}];
        pb   = plane_reg[{cmd.plane, 2'd1}];
        pc   = plane_reg[{cmd.plane, 2'd2}];
        pd   = plane_reg[{cmd.plane, 2'd3}];
        xs   = (pa[PW-1] ^ (bx_lo_reg > bx_hi_reg)) ? bx_lo_reg : bx_hi_reg;
        ys   = (pb[PW-1] ^ (by_lo_reg > by_hi_reg)) ? by_lo_reg : by_hi_reg;
        zs   = (pc[PW-1] ^ (bz_lo_reg > bz_hi_reg)) ? bz_lo_reg : bz_hi_reg;
        vsum = SUM_W'(ma_reg) + SUM_W'(mb_reg) + SUM_W'(mc_reg) + md_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 16; n++)
            begin
                mv_reg[n] <= '0;
                pr_reg[n] <= '0;
            end
            for (int n = 0; n < 24; n++)
            begin
                plane_reg[n] <= '0;
            end
            a_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
            t_valid_reg <= 1'b0;
            cull_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_en)
            begin
                if (which_matrix)
                begin
                    pr_reg[entry_index] <= load_val;
                end
                else
                begin
                    mv_reg[entry_index] <= load_val;
                end
            end
            a_valid_reg <= cmd.build_issue;
            b_last_reg  <= a_valid_reg && (a_tag_reg[1:0] == 2'd3);
            if (b_last_reg)
            begin
                if (b_tag_reg[1:0] == 2'd0)
                begin
                    w_reg <= clip;
                end
                else
                begin
                    plane_reg[{axis_c, 1'b0, b_tag_reg[3:2]}] <= PW'(w_reg) - PW'(clip);
                    plane_reg[{axis_c, 1'b1, b_tag_reg[3:2]}] <= PW'(w_reg) + PW'(clip);
                end
            end
            t_valid_reg <= cmd.test_issue;
            if (cmd.test_start)
            begin
                cull_reg <= 1'b0;
            end
            else if (t_valid_reg && nz_reg && ((vsum < 0) || (vsum == 0)))
            begin
                cull_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build_issue)
        begin
            prod_reg  <= mv_reg[{row_a, k_a}] * pr_reg[{k_a, col_a}];
            a_tag_reg <= cmd.step;
        end
        if (a_valid_reg)
        begin
            acc_reg   <= (a_tag_reg[1:0] == 2'd0) ? ACC_W'(prod_reg)
                                                  : acc_reg + ACC_W'(prod_reg);
            b_tag_reg <= a_tag_reg[5:2];
        end
        if (cmd.test_start)
        begin
            bx_lo_reg <= box_x_min;
            by_lo_reg <= box_y_min;
            bz_lo_reg <= box_z_min;
            bx_hi_reg <= box_x_max;
            by_hi_reg <= box_y_max;
            bz_hi_reg <= box_z_max;
        end
        if (cmd.test_issue)
        begin
            ma_reg <= PROD_W'(pa) * PROD_W'(xs);
            mb_reg <= PROD_W'(pb) * PROD_W'(ys);
            mc_reg <= PROD_W'(pc) * PROD_W'(zs);
            md_reg <= SUM_W'(pd) <<< FRAC_BITS;
            nz_reg <= (pa != 0) || (pb != 0) || (pc != 0) || (pd != 0);
        end
    end

    assign status.culled = cull_reg;

endmodule

// File: rtl/frustum_aabb_culler.sv
// Load words are taken while idle and do not leave the idle state. A build word holds
// the input off while the 64 clip products go through one shared multiplier and the
// pipeline drains. A box test holds the input off through six planes, one per cycle,
// then the compare and the result handoff. While unread, the result word stalls the
// next test.
// Reset (rst_n, asynchronous, active low) clears both matrices and all planes.
module frustum_aabb_culler #(
    parameter int VALUE_WIDTH = fac_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fac_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index, entry_value, box_x_min, box_y_min, box_z_min,
    // box_x_max, box_y_max, box_z_max, then four zero bits.
    input  logic [fac_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // op, which_matrix.
    input  logic [fac_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // visible, then seven zero bits.
    output logic [fac_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);
    import fac_pkg::*;

    fac_cmd_t    cmd;
    fac_status_t status;
    logic        visible;

    // The controller accepts a word only while idle; a finished result waits in
    // its output register, so new words are taken while the result is pending.
    fac_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser[1:0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_visible (visible),
        .cmd         (cmd),
        .status      (status)
    );

    // The datapath holds the matrices and planes, builds the clip matrix
    // one product per cycle and tests one plane per cycle against the
    // corner of the box that lies farthest along the plane normal.
    fac_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .which_matrix (s_axis_tuser[2]),
        .entry_index  (s_axis_tdata[3:0]),
        .entry_value  (s_axis_tdata[35:4]),
        .box_x_min    (s_axis_tdata[67:36]),
        .box_y_min    (s_axis_tdata[99:68]),
        .box_z_min    (s_axis_tdata[131:100]),
        .box_x_max    (s_axis_tdata[163:132]),
        .box_y_max    (s_axis_tdata[195:164]),
        .box_z_max    (s_axis_tdata[227:196])
    );

    assign m_axis_tdata = {7'd0, visible};

endmodule

// File: tb/tb_frustum_aabb_culler.sv
module tb_frustum_aabb_culler;

    import fac_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]         op;
        logic               mat;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] bx [6];
        int                 known;   // -1: use predictor, else the typed-in result
    } cull_word_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [TDATA_IN_W-1:0] s_axis_tdata;
    logic [TUSER_IN_W-1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    frustum_aabb_culler uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copies of the matrix stores and the six planes.
    logic signed [31:0] view_m [16];
    logic signed [31:0] proj_m [16];
    logic signed [32:0] planes [24];
    logic visible_q [$];
    int errors;
    longint cycles;
    bit stim_done;
    bit hold_off;

    function automatic longint floor_q(longint n);
        return n >>> FRAC;
    endfunction

    // Clip matrix: each product is floored on its own, the remainders are summed
    // and floored again, which equals flooring the exact sum.
    function automatic void build_clip_planes();
        logic signed [31:0] clip [16];
        longint p;
        longint qs;
        longint rs;
        longint s;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                qs = 0;
                rs = 0;
                for (int k = 0; k < 4; k++)
                begin
                    p = longint'(view_m[i*4+k]) * longint'(proj_m[k*4+j]);
                    qs += floor_q(p);
                    rs += p - (floor_q(p) << FRAC);
                end
                s = qs + floor_q(rs);
                if (s > 64'sd2147483647)
                    s = 64'sd2147483647;
                else if (s < -64'sd2147483648)
                    s = -64'sd2147483648;
                clip[i*4+j] = s[31:0];
            end
        end
        for (int pl = 0; pl < 6; pl++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (pl % 2 == 0)
                    planes[pl*4+k] = 33'(clip[3+4*k]) - 33'(clip[pl/2+4*k]);
                else
                    planes[pl*4+k] = 33'(clip[3+4*k]) + 33'(clip[pl/2+4*k]);
            end
        end
    endfunction

    // A box is culled when every corner lies at or below some nonzero plane.
    function automatic logic box_visible(cull_word_t w);
        logic signed [127:0] s;
        bit all_out;
        for (int pl = 0; pl < 6; pl++)
        begin
            if (planes[pl*4] == 0 && planes[pl*4+1] == 0 && planes[pl*4+2] == 0
                && planes[pl*4+3] == 0)
                continue;
            all_out = 1;
            for (int c = 0; c < 8; c++)
            begin
                s = (128'(planes[pl*4+3]) <<< FRAC)
                    + 128'(planes[pl*4])   * 128'(w.bx[(c & 1) ? 3 : 0])
                    + 128'(planes[pl*4+1]) * 128'(w.bx[(c & 2) ? 4 : 1])
                    + 128'(planes[pl*4+2]) * 128'(w.bx[(c & 4) ? 5 : 2]);
                if (s > 0)
                    all_out = 0;
            end
            if (all_out)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    // Sends one word, updates the shadow state and queues the expected result.
    task automatic send_word(cull_word_t w);
        logic v;
        s_axis_tdata <= {4'b0, w.bx[5], w.bx[4], w.bx[3], w.bx[2], w.bx[1], w.bx[0],
                         w.val, w.idx};
        s_axis_tuser <= {w.mat, w.op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (w.op)
            OP_LOAD:
                if (w.mat)
                    proj_m[w.idx] = w.val;
                else
                    view_m[w.idx] = w.val;
            OP_BUILD:
                build_clip_planes();
            OP_TEST:
            begin
                v = box_visible(w);
                if (w.known >= 0 && v !== w.known[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("table row disagrees with predictor: %0d vs %0b",
                                 w.known, v);
                end
                visible_q.push_back(v);
            end
            default: ;
        endcase
        // Random gap between words: mostly short, occasionally long.
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 80) : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    function automatic cull_word_t mk(logic [1:0] op, logic mat, logic [3:0] idx,
                                      logic signed [31:0] val, int known);
        cull_word_t w;
        w.op = op;
        w.mat = mat;
        w.idx = idx;
        w.val = val;
        w.known = known;
        for (int i = 0; i < 6; i++)
            w.bx[i] = 0;
        return w;
    endfunction

    function automatic cull_word_t mk_box(logic signed [31:0] lo, logic signed [31:0] hi,
                                          int known);
        cull_word_t w;
        w = mk(OP_TEST, 1'b0, 4'd0, 0, known);
        for (int i = 0; i < 3; i++)
        begin
            w.bx[i] = lo;
            w.bx[i+3] = hi;
        end
        return w;
    endfunction

    function automatic cull_word_t rand_box();
        cull_word_t w;
        w = mk(OP_TEST, 1'($urandom()), 4'($urandom()), $urandom(), -1);
        for (int i = 0; i < 6; i++)
            w.bx[i] = rand_value();
        return w;
    endfunction

    // Stimulus: directed table, then random matrix sets each followed by boxes.
    initial
    begin
        cull_word_t tbl [$];
        cull_word_t w;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        errors = 0;
        stim_done = 0;
        for (int i = 0; i < 16; i++)
        begin
            view_m[i] = 0;
            proj_m[i] = 0;
        end
        for (int i = 0; i < 24; i++)
            planes[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset all planes are zero, so every box is visible.
        tbl.push_back(mk_box(32'sh80000000, 32'sh7fffffff, 1));
        tbl.push_back(mk_box(32'sh7fffffff, 32'sh80000000, 1));
        // Unused op code is ignored.
        tbl.push_back(mk(2'd3, 1'b1, 4'd15, 32'sh7fffffff, -1));
        // Identity matrices: the canonical cube. A box far outside is culled.
        for (int i = 0; i < 4; i++)
        begin
            tbl.push_back(mk(OP_LOAD, 1'b0, 4'(i*5), 32'sh10000, -1));
            tbl.push_back(mk(OP_LOAD, 1'b1, 4'(i*5), 32'sh10000, -1));
        end
        tbl.push_back(mk(OP_BUILD, 1'b0, 4'd0, 0, -1));
        tbl.push_back(mk_box(32'sh50000, 32'sh60000, 0));
        tbl.push_back(mk_box(-32'sh8000, 32'sh8000, 1));
        tbl.push_back(mk_box(32'sh60000, -32'sh60000, 1));
        tbl.push_back(mk_box(32'sh10000, 32'sh20000, -1));
        // Extreme entries saturate the clip matrix.
        tbl.push_back(mk(OP_LOAD, 1'b0, 4'd3, 32'sh7fffffff, -1));
        tbl.push_back(mk(OP_LOAD, 1'b1, 4'd15, 32'sh80000000, -1));
        tbl.push_back(mk(OP_BUILD, 1'b1, 4'd0, 0, -1));
        tbl.push_back(mk_box(32'sh80000000, 32'sh80000000, -1));
        tbl.push_back(mk_box(32'sh7fffffff, 32'sh7fffffff, -1));
        tbl.push_back(rand_box());
        foreach (tbl[i])
            send_word(tbl[i]);

        for (int n = 0; n < 1250; )
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                // New matrix set: a few loads, possibly a full refresh, then usually a build.
                repeat ($urandom_range(1, 32))
                begin
                    w = mk(OP_LOAD, 1'($urandom()), 4'($urandom()), rand_value(), -1);
                    send_word(w);
                    n++;
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    send_word(mk(OP_BUILD, 1'($urandom()), 4'($urandom()), $urandom(), -1));
                    n++;
                end
            end
            repeat ($urandom_range(1, 12))
            begin
                w = ($urandom_range(0, 19) == 0) ? mk(2'd3, 1'($urandom()), 4'($urandom()),
                                                      $urandom(), -1) : rand_box();
                send_word(w);
                n++;
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    initial
    begin
        hold_off = 0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
    end

    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 49) == 0)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            m_axis_tready <= ~m_axis_tready;
        else
            m_axis_tready <= 1'b1;
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (visible_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: %h", m_axis_tdata);
            end
            else
            begin
                logic want;
                want = visible_q.pop_front();
                if (m_axis_tdata !== {7'b0, want})
                begin
                    errors++;
                    if (errors <= 10)
                        $display("visible mismatch: expected %0b got %h", want, m_axis_tdata);
                end
            end
        end
    end

    // End of run and watchdog.
    initial
    begin
        cycles = 0;
        while (!(stim_done && visible_q.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("frustum_aabb_culler regression: fail");
            $finish;
        end
        else
        begin
            repeat (100) @(posedge clk);
            if (errors == 0)
                $display("frustum_aabb_culler regression: pass");
            else
                $display("frustum_aabb_culler regression: fail");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/fac_pkg.sv
rtl/fac_ctrl.sv
rtl/fac_datapath.sv
rtl/frustum_aabb_culler.sv
tb/tb_frustum_aabb_culler.sv
